// ===== hw/rtl/session_slot_table_unit_assert.svh =====
// Assertion macros for the session slot table
`ifndef SESSION_SLOT_TABLE_UNIT_ASSERT_SVH
`define SESSION_SLOT_TABLE_UNIT_ASSERT_SVH
// implication checked every cycle outside reset
`define SST_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// next-cycle implication
`define SST_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ===== hw/rtl/sst_pkg.sv =====
// Package: types, codes and lifecycle table for the session slot table
package sst_pkg;
    localparam int CAPACITY_DEF   = 64;
    localparam int GEN_BITS_DEF   = 16;
    localparam int LAST_STAGE_DEF = 4;

    localparam logic [3:0] ST_FREE        = 4'd0;
    localparam logic [3:0] ST_RESERVED    = 4'd1;
    localparam logic [3:0] ST_RESOLVING   = 4'd2;
    localparam logic [3:0] ST_CONNECTING  = 4'd3;
    localparam logic [3:0] ST_HANDSHAKING = 4'd4;
    localparam logic [3:0] ST_OPEN        = 4'd5;
    localparam logic [3:0] ST_DRAINING    = 4'd6;
    localparam logic [3:0] ST_TERMINAL    = 4'd7;
    localparam logic [3:0] ST_RETIRED     = 4'd8;

    localparam logic [2:0] RC_OK      = 3'd0;
    localparam logic [2:0] RC_INVAL   = 3'd1;
    localparam logic [2:0] RC_NOENT   = 3'd2;
    localparam logic [2:0] RC_BUSY    = 3'd3;
    localparam logic [2:0] RC_ALREADY = 3'd4;
    localparam logic [2:0] RC_PROTO   = 3'd5;
    localparam logic [2:0] RC_NOFREE  = 3'd6;

    localparam logic [3:0] FN_RESERVE  = 4'd0;
    localparam logic [3:0] FN_RELEASE  = 4'd1;
    localparam logic [3:0] FN_QUERY    = 4'd2;
    localparam logic [3:0] FN_TRANS    = 4'd3;
    localparam logic [3:0] FN_BCLOSE   = 4'd4;
    localparam logic [3:0] FN_FCLOSE   = 4'd5;
    localparam logic [3:0] FN_FAIL     = 4'd6;
    localparam logic [3:0] FN_TAKE     = 4'd7;
    localparam logic [3:0] FN_RECYCLE  = 4'd8;

    localparam logic [1:0] TK_NONE   = 2'd0;
    localparam logic [1:0] TK_CLOSED = 2'd1;
    localparam logic [1:0] TK_FAILED = 2'd2;

    // back-end sequencer
    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_OUT
    } t_be_state;

    // classified command handed from front to back
    typedef struct packed {
        logic [3:0]  func;
        logic        pre_done;   // result decided in front
        logic [2:0]  pre_code;
        logic        slot_ok;
        logic [6:0]  slot;
        logic [15:0] generation;
        logic [3:0]  next_state;
        logic [15:0] fail_status;
        logic [2:0]  fail_stage;
    } t_cmd;

    function automatic logic step_allowed(input logic [3:0] cur, input logic [3:0] nxt);
        logic ok;
        begin
            case (cur)
                ST_RESERVED:    ok = nxt == ST_RESOLVING || nxt == ST_CONNECTING ||
                                     nxt == ST_DRAINING;
                ST_RESOLVING:   ok = nxt == ST_CONNECTING || nxt == ST_DRAINING;
                ST_CONNECTING:  ok = nxt == ST_HANDSHAKING || nxt == ST_OPEN ||
                                     nxt == ST_DRAINING;
                ST_HANDSHAKING: ok = nxt == ST_OPEN || nxt == ST_DRAINING;
                ST_OPEN:        ok = nxt == ST_DRAINING;
                default:        ok = 1'b0;
            endcase
            return ok;
        end
    endfunction
endpackage

// ===== hw/rtl/session_slot_table_unit.sv =====
// Top level of the session slot table
// Session slot table: one command in, one result out. A command passes a
// two-entry queue and then four steps in the back end (take from the queue
// with the stack top read, entry read, execute and write, result hold, which
// waits while i_stall is high). The back end handles one command at a time as
// an entry read-modify-write, so it takes no new command until the last is done.
// No clearing pass is needed after reset; the first command can enter at once.
`include "session_slot_table_unit_assert.svh"
module session_slot_table_unit import sst_pkg::*; #(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int GEN_BITS   = GEN_BITS_DEF,
    parameter int LAST_STAGE = LAST_STAGE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [3:0]  i_func,
    input  logic [6:0]  i_slot,
    input  logic [15:0] i_generation,
    input  logic [3:0]  i_next_state,
    input  logic signed [15:0] i_fail_status,
    input  logic [2:0]  i_fail_stage,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_code,
    output logic [6:0]  o_out_slot,
    output logic [15:0] o_out_generation,
    output logic [3:0]  o_out_state,
    output logic [1:0]  o_term_kind,
    output logic signed [15:0] o_term_status,
    output logic [2:0]  o_term_stage
);
    logic w_cmd_valid, w_pop, w_busy;
    t_cmd w_cmd;

    sst_front #(.CAPACITY(CAPACITY), .LAST_STAGE(LAST_STAGE)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_func, .i_slot, .i_generation,
        .i_next_state, .i_fail_status, .i_fail_stage,
        .o_cmd_valid(w_cmd_valid), .o_cmd(w_cmd), .i_cmd_pop(w_pop)
    );

    sst_back #(.CAPACITY(CAPACITY), .GEN_BITS(GEN_BITS)) u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(w_cmd_valid), .i_cmd(w_cmd),
        .o_cmd_pop(w_pop), .o_valid, .i_stall, .o_code, .o_out_slot,
        .o_out_generation, .o_out_state, .o_term_kind, .o_term_status,
        .o_term_stage, .o_busy(w_busy)
    );

    `SST_ASSERT_IMP(a_pop_idle, i_clk, i_rst_n, w_pop, w_cmd_valid && !w_busy)
    `SST_ASSERT_NEXT(a_out_held, i_clk, i_rst_n, o_valid && i_stall, o_valid)
    `SST_ASSERT_IMP(a_slot_ok, i_clk, i_rst_n, o_valid && o_out_slot != 7'd0,
        o_code == RC_OK)
endmodule

// ===== hw/rtl/sst_front.sv =====
// Front end: accepts commands, checks arguments, queues classified items
module sst_front import sst_pkg::*; #(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int LAST_STAGE = LAST_STAGE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [3:0]  i_func,
    input  logic [6:0]  i_slot,
    input  logic [15:0] i_generation,
    input  logic [3:0]  i_next_state,
    input  logic [15:0] i_fail_status,
    input  logic [2:0]  i_fail_stage,
    output logic        o_cmd_valid,
    output t_cmd        o_cmd,
    input  logic        i_cmd_pop
);
    localparam int QD = 2;

    t_cmd       r_q [QD];
    logic [1:0] r_cnt, n_cnt;
    logic       r_rd, n_rd, r_wr, n_wr;
    t_cmd       w_cmd;
    logic       w_push;

    // classify
    always_comb begin
        w_cmd             = '0;
        w_cmd.func        = i_func;
        w_cmd.slot        = i_slot;
        w_cmd.generation  = i_generation;
        w_cmd.next_state  = i_next_state;
        w_cmd.fail_status = i_fail_status;
        w_cmd.fail_stage  = i_fail_stage;
        w_cmd.slot_ok     = i_slot != 7'd0 && i_generation != 16'd0 &&
                            {25'd0, i_slot} <= 32'(CAPACITY);
        if (i_func > FN_RECYCLE) begin
            w_cmd.pre_done = 1'b1;
            w_cmd.pre_code = RC_INVAL;
        end else if (i_func == FN_FAIL && (!i_fail_status[15] || i_fail_stage == 3'd0 ||
                     {29'd0, i_fail_stage} > 32'(LAST_STAGE))) begin
            w_cmd.pre_done = 1'b1;
            w_cmd.pre_code = RC_INVAL;
        end else if (i_func != FN_RESERVE && !w_cmd.slot_ok) begin
            w_cmd.pre_done = 1'b1;
            w_cmd.pre_code = RC_NOENT;
        end
    end

    assign o_stall     = r_cnt == 2'(QD);
    assign w_push      = i_valid && !o_stall;
    assign o_cmd_valid = r_cnt != 2'd0;
    assign o_cmd       = r_q[r_rd];

    // queue pointers
    always_comb begin
        n_cnt = r_cnt + 2'(w_push) - 2'(i_cmd_pop);
        n_wr  = r_wr ^ w_push;
        n_rd  = r_rd ^ i_cmd_pop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_rd  <= n_rd;
            r_wr  <= n_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_cmd;
        end
    end
endmodule

// ===== hw/rtl/sst_back.sv =====
// Back end: entry table, free-slot stack and command execution
module sst_back import sst_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int GEN_BITS = GEN_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    input  t_cmd        i_cmd,
    output logic        o_cmd_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_code,
    output logic [6:0]  o_out_slot,
    output logic [15:0] o_out_generation,
    output logic [3:0]  o_out_state,
    output logic [1:0]  o_term_kind,
    output logic [15:0] o_term_status,
    output logic [2:0]  o_term_stage,
    output logic        o_busy
);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int DW = $clog2(CAPACITY + 1);
    localparam int EW = 4 + GEN_BITS + 2 + 16 + 3 + 1;
    localparam logic [GEN_BITS-1:0] GMAX = '1;

    typedef struct packed {
        logic [3:0]          st;
        logic [GEN_BITS-1:0] gen;
        logic [1:0]          kind;
        logic [15:0]         status;
        logic [2:0]          stage;
        logic                taken;
    } t_entry;

    // entry and stack memories; entries not yet written read as reset
    logic [EW-1:0]  r_mem   [CAPACITY];
    logic [IW-1:0]  r_stk   [CAPACITY];
    logic           r_ev    [CAPACITY];
    logic           r_sv    [CAPACITY];
    logic [DW-1:0]  r_depth, n_depth;
    logic [DW-1:0]  r_act, n_act;

    t_be_state      r_st, n_st;
    t_cmd           r_cmd;
    logic [IW-1:0]  r_idx, n_idx;
    logic [EW-1:0]  r_rdat;
    logic           r_rev;
    logic [IW-1:0]  r_srd;
    logic           r_ssv;
    logic [IW-1:0]  w_top;
    t_entry         w_e, w_ne;
    logic           w_we, w_push;
    logic [IW-1:0]  w_widx;
    logic [2:0]     n_code;
    logic [6:0]     n_oslot;
    logic [15:0]    n_ogen;
    logic [3:0]     n_ostate;
    logic [1:0]     n_tk;
    logic [15:0]    n_ts;
    logic [2:0]     n_tst;
    logic           w_take;
    logic           w_rel_ok, w_last;
    logic [DW-1:0]  w_tpos;

    assign o_busy    = r_st != S_IDLE;
    assign w_take    = r_st == S_IDLE && i_cmd_valid;
    assign o_cmd_pop = w_take;
    assign o_valid   = r_st == S_OUT;

    // stack top position
    assign w_tpos = r_depth - DW'(1);
    assign w_top  = r_ssv ? r_srd : IW'(CAPACITY - 1 - 32'(w_tpos[IW-1:0]));

    always_comb begin
        w_e = r_rev ? t_entry'(r_rdat) : '0;
    end

    // execute one command on one entry
    always_comb begin
        w_ne     = w_e;
        w_we     = 1'b0;
        w_push   = 1'b0;
        w_widx   = r_idx;
        n_depth  = r_depth;
        n_act    = r_act;
        n_code   = RC_OK;
        n_oslot  = '0;
        n_ogen   = '0;
        n_ostate = '0;
        n_tk     = '0;
        n_ts     = '0;
        n_tst    = '0;
        w_last   = w_e.gen == GMAX;
        w_rel_ok = r_act != '0 && (w_last || r_depth < DW'(CAPACITY));
        if (r_cmd.pre_done) begin
            n_code = r_cmd.pre_code;
        end else if (r_cmd.func == FN_RESERVE) begin
            if (r_depth == '0) begin
                n_code = RC_NOFREE;
            end else if (w_e.st != ST_FREE) begin
                n_code = RC_PROTO;
            end else begin
                n_depth = r_depth - DW'(1);
                n_act   = r_act + DW'(1);
                w_ne    = '0;
                w_ne.st = ST_RESERVED;
                w_ne.gen = (w_e.gen == '0) ? GEN_BITS'(1) : w_e.gen;
                w_we    = 1'b1;
                n_oslot = 7'(32'(r_idx) + 1);
                n_ogen  = 16'(w_ne.gen);
            end
        end else if (w_e.st == ST_FREE || w_e.st == ST_RETIRED ||
                     32'(w_e.gen) != 32'(r_cmd.generation)) begin
            n_code = RC_NOENT;
        end else begin
            case (r_cmd.func)
                FN_RELEASE, FN_RECYCLE: begin
                    if (r_cmd.func == FN_RELEASE ? w_e.st != ST_RESERVED :
                        (w_e.st != ST_TERMINAL || !w_e.taken)) begin
                        n_code = RC_BUSY;
                    end else if (!w_rel_ok) begin
                        n_code = RC_PROTO;
                    end else begin
                        n_act = r_act - DW'(1);
                        w_we  = 1'b1;
                        w_ne  = '0;
                        w_ne.gen = w_e.gen;
                        if (w_last) begin
                            w_ne.st = ST_RETIRED;
                        end else begin
                            w_ne.gen = w_e.gen + GEN_BITS'(1);
                            w_ne.st  = ST_FREE;
                            w_push   = 1'b1;
                            n_depth  = r_depth + DW'(1);
                        end
                    end
                end
                FN_QUERY: n_ostate = w_e.st;
                FN_TRANS: begin
                    if (step_allowed(w_e.st, r_cmd.next_state)) begin
                        w_ne.st = r_cmd.next_state;
                        w_we    = 1'b1;
                    end else begin
                        n_code = RC_PROTO;
                    end
                end
                FN_BCLOSE: begin
                    if (w_e.st == ST_DRAINING || w_e.st == ST_TERMINAL) begin
                        n_code = RC_ALREADY;
                    end else if (!step_allowed(w_e.st, ST_DRAINING)) begin
                        n_code = RC_PROTO;
                    end else begin
                        w_ne.st = ST_DRAINING;
                        w_we    = 1'b1;
                    end
                end
                FN_FCLOSE: begin
                    if (w_e.st == ST_TERMINAL) begin
                        n_code = RC_ALREADY;
                    end else if (w_e.st != ST_DRAINING) begin
                        n_code = RC_PROTO;
                    end else begin
                        w_ne.st = ST_TERMINAL;
                        w_ne.kind = TK_CLOSED;
                        w_ne.status = '0;
                        w_ne.stage = '0;
                        w_ne.taken = 1'b0;
                        w_we = 1'b1;
                    end
                end
                FN_FAIL: begin
                    if (w_e.st == ST_TERMINAL) begin
                        n_code = RC_ALREADY;
                    end else begin
                        w_ne.st = ST_TERMINAL;
                        w_ne.kind = TK_FAILED;
                        w_ne.status = r_cmd.fail_status;
                        w_ne.stage = r_cmd.fail_stage;
                        w_ne.taken = 1'b0;
                        w_we = 1'b1;
                    end
                end
                FN_TAKE: begin
                    if (w_e.st != ST_TERMINAL) begin
                        n_code = RC_BUSY;
                    end else if (w_e.taken) begin
                        n_code = RC_ALREADY;
                    end else begin
                        n_tk  = w_e.kind;
                        n_ts  = w_e.status;
                        n_tst = w_e.stage;
                        w_ne.taken = 1'b1;
                        w_we = 1'b1;
                    end
                end
                default: n_code = RC_INVAL;
            endcase
        end
    end

    // sequencer
    always_comb begin
        n_st  = r_st;
        n_idx = r_idx;
        case (r_st)
            S_IDLE: if (w_take) n_st = S_READ;
            S_READ: begin
                n_idx = (r_cmd.func == FN_RESERVE) ? w_top : IW'(32'(r_cmd.slot) - 1);
                n_st  = S_EXEC;
            end
            S_EXEC: n_st = S_OUT;
            S_OUT:  if (!i_stall) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_depth <= DW'(CAPACITY);
            r_act   <= '0;
            for (int i = 0; i < CAPACITY; i++) begin
                r_ev[i] <= 1'b0;
                r_sv[i] <= 1'b0;
            end
        end else begin
            r_st <= n_st;
            if (r_st == S_EXEC) begin
                r_depth <= n_depth;
                r_act   <= n_act;
                if (w_we) r_ev[w_widx] <= 1'b1;
                if (w_push) r_sv[r_depth[IW-1:0]] <= 1'b1;
            end
        end
    end

    // stack top read, entry read and write
    always_ff @(posedge i_clk) begin
        r_srd <= r_stk[w_tpos[IW-1:0]];
        r_ssv <= r_sv[w_tpos[IW-1:0]];
        if (w_take) r_cmd <= i_cmd;
        r_idx <= n_idx;
        if (r_st == S_READ) begin
            r_rdat <= r_mem[n_idx];
            r_rev  <= r_ev[n_idx];
        end
        if (r_st == S_EXEC) begin
            if (w_we) r_mem[w_widx] <= EW'(w_ne);
            if (w_push) r_stk[r_depth[IW-1:0]] <= r_idx;
            o_code           <= n_code;
            o_out_slot       <= n_oslot;
            o_out_generation <= n_ogen;
            o_out_state      <= n_ostate;
            o_term_kind      <= n_tk;
            o_term_status    <= n_ts;
            o_term_stage     <= n_tst;
        end
    end
endmodule
